FILE: rtl/core/stkins_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkins_pkg
// Shared constants and types for the stack with insert-at-depth core.
// ----------------------------------------------------------------------------
package stkins_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned IN_RAW_W    = OP_W + WORD_W + POS_W;
  localparam int unsigned IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W   = WORD_W + STATUS_W + CNT_W + 1;
  localparam int unsigned OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_REACHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd3;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              shift_dn;  // open a slot and place word there
    logic              shift_up;  // drop the top entry
    logic [IDX_W-1:0]  slot;      // slot counted from the top
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

FILE: rtl/core/stkins_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkins_cell
// One stack entry: holds, takes its upper or lower neighbor, or loads a word.
// ----------------------------------------------------------------------------
module stkins_cell (
  input  logic                       clk_i,
  input  stkins_pkg::cell_cmd_t      cmd_i,
  input  logic [stkins_pkg::IDX_W-1:0]  idx_i,
  input  logic [stkins_pkg::WORD_W-1:0] up_i,
  input  logic [stkins_pkg::WORD_W-1:0] dn_i,
  output logic [stkins_pkg::WORD_W-1:0] q_o
);
  import stkins_pkg::*;

  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_dn) begin
      if (idx_i > cmd_i.slot) begin
        data_d = up_i;
      end else if (idx_i == cmd_i.slot) begin
        data_d = cmd_i.word;
      end
    end else if (cmd_i.shift_up) begin
      data_d = dn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

FILE: rtl/core/stkins_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkins_chain
// Row of stack cells, top of stack in cell zero, each linked to its neighbors.
// ----------------------------------------------------------------------------
module stkins_chain (
  input  logic                          clk_i,
  input  stkins_pkg::cell_cmd_t         cmd_i,
  output logic [stkins_pkg::WORD_W-1:0] top_o
);
  import stkins_pkg::*;

  logic [WORD_W-1:0] cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_w;
    logic [WORD_W-1:0] dn_w;

    if (i == 0) begin : g_top
      assign up_w = cmd_i.word;
    end else begin : g_mid
      assign up_w = cell_q[i-1];
    end

    // bottom cell refills with itself on a pop
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_w = cell_q[i];
    end else begin : g_nbot
      assign dn_w = cell_q[i+1];
    end

    stkins_cell u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd_i),
      .idx_i (IDX_W'(i)),
      .up_i  (up_w),
      .dn_i  (dn_w),
      .q_o   (cell_q[i])
    );
  end

  assign top_o = cell_q[0];

endmodule

FILE: rtl/core/stack_with_insert_at_depth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_insert_at_depth_core
// Bounded LIFO of signed words with push, pop and insert below the top entries.
// ----------------------------------------------------------------------------
// The whole row of cells shifts at once, so a new word is taken every cycle
// that the output register is free, and its result appears in that register
// on the next edge. The output register is the only stall point; a new word
// is taken whenever it is empty or being read out in the same cycle. Stack
// contents are not cleared by reset; only the fill count and valid flag are.
// ----------------------------------------------------------------------------
module stack_with_insert_at_depth_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // operation[1:0], value[33:2], position[41:34], zero pad above
  input  logic [stkins_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // popped_value[31:0], status[33:32], entry_count[38:34], is_empty[39]
  output logic [stkins_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import stkins_pkg::*;

  logic                in_acc;
  logic [OP_W-1:0]     op;
  logic [WORD_W-1:0]   value;
  logic [POS_W-1:0]    position;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    want;
  logic [CMP_W-1:0]    fill_w;
  logic [CMP_W-1:0]    depth_w;
  logic [WORD_W-1:0]   top;
  cell_cmd_t           cmd;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  logic [WORD_W-1:0]   popped_q, popped_d;
  logic [STATUS_W-1:0] status_q, status_d;

  assign op       = s_axis_tdata_i[OP_W-1:0];
  assign value    = s_axis_tdata_i[OP_W+WORD_W-1:OP_W];
  assign position = s_axis_tdata_i[IN_RAW_W-1:OP_W+WORD_W];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign full    = (count_q == CNT_W'(STACK_DEPTH));
  assign empty   = (count_q == '0);
  assign fill_w  = CMP_W'(count_q);
  assign want    = CMP_W'(position) - CMP_W'(1);
  assign depth_w = (want < fill_w) ? want : fill_w;

  always_comb begin
    cmd          = '0;
    cmd.word     = value;
    count_d      = count_q;
    popped_d     = '0;
    status_d     = ST_OK;
    case (op)
      OP_PUSH: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          cmd.shift_dn = 1'b1;
          count_d      = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          cmd.shift_up = 1'b1;
          popped_d     = top;
          count_d      = count_q - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          cmd.shift_dn = 1'b1;
          count_d      = count_q + CNT_W'(1);
          if (position == '0) begin
            status_d = ST_NOT_REACHED;
          end else begin
            // depth is at most the fill count, which stays below STACK_DEPTH here, so it fits a cell index
            cmd.slot = IDX_W'(depth_w);
            status_d = (want <= fill_w) ? ST_OK : ST_NOT_REACHED;
          end
        end
      end
      default: begin
      end
    endcase
    if (!in_acc) begin
      cmd.shift_dn = 1'b0;
      cmd.shift_up = 1'b0;
    end
  end

  stkins_chain u_chain (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .top_o (top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({(count_q == '0), count_q, status_q, popped_q});

  // fill count never runs past the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // a pop on a non-empty stack removes exactly one entry
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_POP && count_q != '0) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not drop one entry");

  // underflow and overflow results never carry a popped word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_UNDERFLOW || status_q == ST_OVERFLOW)) |-> popped_q == '0)
    else $error("error result carries a word");

  // a failed push or insert leaves the count unchanged
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && (op == OP_PUSH || op == OP_INSERT)) |=> count_q == $past(count_q))
    else $error("overflow changed the fill count");

endmodule

FILE: bench/tb_stack_with_insert_at_depth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_with_insert_at_depth_core
// Self-checking bench for the stack core with push, pop and insert-at-depth.
// ----------------------------------------------------------------------------
// A shadow stack in the bench predicts every result word as the command word
// is taken. Results are compared field by field in arrival order. Directed
// tests cover the empty and full stack, insert positions around the current
// depth and the unused opcode. A random phase picks fill or drain bias anew
// every 40 words, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_stack_with_insert_at_depth_core;
  import stkins_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_CYCLES = 500;
  localparam int unsigned RANDOM_WORDS    = 425;
  localparam int unsigned MAX_PRINTS      = 40;

  // result word as it leaves the core, lowest field last
  typedef struct packed {
    logic                is_empty;
    logic [CNT_W-1:0]    entry_count;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   popped_value;
  } stack_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // shadow copy of the stack, index 0 is the bottom
  logic [WORD_W-1:0] shadow_cells [STACK_DEPTH];
  int unsigned       shadow_fill;

  stack_result_t expected_results [$];
  stack_result_t got_result;
  stack_result_t want_result;

  int unsigned error_count;
  int unsigned sink_wait;
  int unsigned quiet_cycles;
  bit          no_idle;

  stack_with_insert_at_depth_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // applies one command to the shadow stack and returns the result word
  function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] op,
                                                   input logic [WORD_W-1:0] value,
                                                   input logic [POS_W-1:0] pos);
    stack_result_t res;
    int unsigned   depth;
    int unsigned   want;
    int unsigned   slot;
    bit            store;
    res    = '0;
    res.status = ST_OK;
    depth  = 0;
    store  = 1'b0;
    case (op)
      OP_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) res.status = ST_OVERFLOW;
        else store = 1'b1;
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          shadow_fill--;
          res.popped_value = shadow_cells[shadow_fill];
        end
      end
      OP_INSERT: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (pos == 0) begin
          // position zero lands on top but is flagged
          res.status = ST_NOT_REACHED;
          store      = 1'b1;
        end else begin
          want       = pos - 1;
          depth      = (want < shadow_fill) ? want : shadow_fill;
          res.status = (want <= shadow_fill) ? ST_OK : ST_NOT_REACHED;
          store      = 1'b1;
        end
      end
      default: ;
    endcase
    if (store) begin
      slot = shadow_fill - depth;
      for (int i = shadow_fill; i > slot; i--) shadow_cells[i] = shadow_cells[i-1];
      shadow_cells[slot] = value;
      shadow_fill++;
    end
    res.entry_count = shadow_fill[CNT_W-1:0];
    res.is_empty    = (shadow_fill == 0);
    return res;
  endfunction

  // drives one command word and predicts its result once it is taken
  task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int unsigned          gap;
    logic [IN_DATA_W-1:0] data;
    gap  = no_idle ? 0 : $urandom_range(0, 19);
    data = '0;
    data[POS_W+WORD_W+OP_W-1:0] = {pos, value, op};
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    expected_results.push_back(apply_stack_op(op, value, pos));
  endtask

  // stops offering words, then waits for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_stack();
    send_word(OP_POP, $urandom, 8'd0);
    send_word(OP_UNUSED, $urandom, POS_W'($urandom_range(0, 255)));
  endtask

  task automatic test_insert_depths();
    send_word(OP_INSERT, 32'h0000_0001, 8'd0);
    send_word(OP_INSERT, 32'h0000_0002, 8'd1);
    send_word(OP_PUSH, 32'h8000_0000, 8'd0);
    send_word(OP_PUSH, 32'h7FFF_FFFF, 8'd0);
    // far too deep, goes to the bottom
    send_word(OP_INSERT, 32'hFFFF_FFFF, 8'd255);
    send_word(OP_INSERT, 32'h0000_0003, 8'd3);
    // exactly one below the bottom entry still counts as reached
    send_word(OP_INSERT, 32'h0000_0004, POS_W'(shadow_fill + 1));
  endtask

  task automatic test_full_stack();
    while (shadow_fill < STACK_DEPTH)
      send_word(OP_PUSH, $urandom, POS_W'($urandom_range(0, 255)));
    send_word(OP_PUSH, 32'hDEAD_BEEF, 8'd0);
    send_word(OP_INSERT, 32'h1234_5678, 8'd1);
  endtask

  task automatic test_pop_order();
    repeat (3) send_word(OP_POP, $urandom, POS_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    bit                filling;
    int unsigned       r;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) filling = 1'($urandom_range(0, 1));
      if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // hold off once until the pipeline is empty
      if (n == RANDOM_WORDS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (filling) op = (r < 45) ? OP_PUSH : (r < 80) ? OP_INSERT : OP_POP;
      else op = (r < 25) ? OP_PUSH : (r < 40) ? OP_INSERT : OP_POP;
      case ($urandom_range(0, 9))
        0:       pos = '0;
        1:       pos = 8'd1;
        2, 3:    pos = POS_W'($urandom_range(0, 255));
        default: pos = POS_W'($urandom_range(1, shadow_fill + 2));
      endcase
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        default: value = $urandom;
      endcase
      send_word(op, value, pos);
    end
    no_idle = 1'b0;
  endtask

  // result checker and sink stall draw
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_result = m_axis_tdata_o;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_axis_tdata_o));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.popped_value !== want_result.popped_value)
          report_mismatch($sformatf("popped_value got %h want %h",
                                    got_result.popped_value, want_result.popped_value));
        if (got_result.status !== want_result.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    got_result.status, want_result.status));
        if (got_result.entry_count !== want_result.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    got_result.entry_count, want_result.entry_count));
        if (got_result.is_empty !== want_result.is_empty)
          report_mismatch($sformatf("is_empty got %b want %b",
                                    got_result.is_empty, want_result.is_empty));
      end
      sink_wait = no_idle ? 0 : $urandom_range(0, 19);
    end
  end

  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ends the run if neither stream moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
          $display("watchdog: no word moved for %0d cycles", quiet_cycles);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    error_count     = 0;
    sink_wait       = 0;
    quiet_cycles    = 0;
    no_idle         = 1'b0;
    shadow_fill     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_stack();
    test_insert_depths();
    test_full_stack();
    test_pop_order();
    test_random_traffic();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
